FILE: rtl/lvd_pkg.sv
// ----------------------------------------------------------------------------
// lvd_pkg
// Shared types and constants of the length-prefixed value decoder.
// ----------------------------------------------------------------------------
package lvd_pkg;

   // parser phase
   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_PREFIX      = 3'd1,
      PH_LONG_PREFIX = 3'd2,
      PH_PAYLOAD     = 3'd3,
      PH_DISCARD     = 3'd4
   } phase_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_TRUNC  = 2'd1,
      ST_BADLEN = 2'd2,
      ST_NOTERM = 2'd3
   } status_type;

   // value type codes
   typedef enum logic [1:0] {
      TY_NONE   = 2'd0,
      TY_INT    = 2'd1,
      TY_STRING = 2'd2,
      TY_BINARY = 2'd3
   } value_kind_type;

   // prefix byte boundaries
   localparam logic [7:0]  SHORT_PREFIX_MIN = 8'd240;
   localparam logic [7:0]  SHORT_PREFIX_MAX = 8'd252;
   localparam logic [7:0]  LONG_PREFIX_CODE = 8'd255;
   localparam logic [7:0]  MULTI_PREFIX_BASE = 8'd251;
   localparam logic [31:0] INT_MAX_BYTES    = 32'd8;

   // reset value of the long length limit
   localparam logic [31:0] MAX_LONG_LENGTH_RESET = 32'd67108864;

endpackage

FILE: rtl/lvd_channels.sv
// ----------------------------------------------------------------------------
// lvd channels
// Valid/ready channel interfaces for requests, responses and the register port.
// ----------------------------------------------------------------------------

// request channel: one byte of the encoded buffer
interface lvd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_buffer;
   logic [1:0] value_type;

   modport source (output valid, output data_byte, output end_of_buffer,
                   output value_type, input ready);
   modport sink   (input valid, input data_byte, input end_of_buffer,
                   input value_type, output ready);
endinterface

// response channel: one decoded value or error
interface lvd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] int_value;
   logic [31:0]        value_length;
   logic [1:0]         status;

   modport source (output valid, output int_value, output value_length,
                   output status, input ready);
   modport sink   (input valid, input int_value, input value_length,
                   input status, output ready);
endinterface

// register write channel: long length limit
interface lvd_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] wdata;

   modport source (output valid, output wdata, input ready);
   modport sink   (input valid, input wdata, output ready);
endinterface

FILE: rtl/length_prefixed_value_decoder_top.sv
// ----------------------------------------------------------------------------
// length_prefixed_value_decoder_top
// Byte-serial parser of length-prefixed values with one response per value.
// ----------------------------------------------------------------------------
// Usage
//   req_chan carries one byte of the encoded buffer per request, with its
//   end_of_buffer mark and the value type (sampled at a value's first byte).
//   rsp_chan gives one response when a value completes or an error is found:
//   integer, decoded length and status. csr_chan writes the long length
//   limit; it is always ready and should only be written while idle.
// Pipeline and throughput
//   A request is taken into an input register and parsed from there; its
//   response, if any, is loaded into the response register. One request per
//   cycle is sustained while no response waits on rsp_chan; the per-byte
//   parser step is a 32-bit count and compare.
// Reset
//   Synchronous, active high: parser waits for a first prefix byte, the
//   limit returns to 67108864 and both pipeline registers are empty.
// Stall
//   While a response waits on rsp_chan, the input register holds one more
//   request; after that req_chan.ready drops until the response is taken.
// ----------------------------------------------------------------------------
module length_prefixed_value_decoder_top (
   input logic      clock,
   input logic      reset,
   lvd_req_if.sink   req_chan,
   lvd_rsp_if.source rsp_chan,
   lvd_csr_if.sink   csr_chan
);

   // register port
   logic [31:0] max_len_ff;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_eob_ff;
   logic [1:0] s1_type_ff;

   // parser state
   lvd_pkg::phase_type      phase_ff, phase_in;
   logic [2:0]              pleft_ff, pleft_in;
   logic [31:0]             len_ff, len_in;
   logic [31:0]             pay_ff, pay_in;
   logic [63:0]             int_ff, int_in;
   lvd_pkg::value_kind_type held_ff, held_in;
   logic [7:0]              last_ff, last_in;
   lvd_pkg::status_type     deferr_ff, deferr_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [63:0]  rsp_int_ff;
   logic [31:0]         rsp_len_ff;
   lvd_pkg::status_type rsp_status_ff;

   // step outputs
   logic                advance, proc;
   logic                emit;
   logic [63:0]         emit_val;
   logic [31:0]         emit_len;
   lvd_pkg::status_type emit_status;
   logic                lk_go;
   logic [31:0]         lk_len;
   logic [31:0]         acc;
   logic [2:0]          pleft_dec;
   logic [31:0]         pay_dec;

   // handshake
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign proc           = s1_valid_ff && advance;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.int_value    = rsp_int_ff;
   assign rsp_chan.value_length = rsp_len_ff;
   assign rsp_chan.status       = rsp_status_ff;

   // long length limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= lvd_pkg::MAX_LONG_LENGTH_RESET;
      end else if (csr_chan.valid) begin
         max_len_ff <= csr_chan.wdata;
      end
   end

   // input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         s1_valid_in = 1'b1;
      end else if (proc) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_byte_ff <= req_chan.data_byte;
         s1_eob_ff  <= req_chan.end_of_buffer;
         s1_type_ff <= req_chan.value_type;
      end
   end

   // one parser step per byte
   always_comb begin
      phase_in    = phase_ff;
      pleft_in    = pleft_ff;
      len_in      = len_ff;
      pay_in      = pay_ff;
      int_in      = int_ff;
      held_in     = held_ff;
      last_in     = last_ff;
      deferr_in   = deferr_ff;
      emit        = 1'b0;
      emit_val    = '0;
      emit_len    = '0;
      emit_status = lvd_pkg::ST_OK;
      lk_go       = 1'b0;
      lk_len      = '0;
      acc         = {len_ff[23:0], s1_byte_ff};
      pleft_dec   = pleft_ff - 3'd1;
      pay_dec     = pay_ff - 32'd1;

      if (proc) begin
         unique case (phase_ff)
            lvd_pkg::PH_IDLE: begin
               held_in = lvd_pkg::value_kind_type'(s1_type_ff);
               if (s1_byte_ff < lvd_pkg::SHORT_PREFIX_MIN) begin
                  lk_go  = 1'b1;
                  lk_len = {24'd0, s1_byte_ff};
               end else begin
                  if (s1_byte_ff <= lvd_pkg::SHORT_PREFIX_MAX) begin
                     len_in   = {28'd0, s1_byte_ff[3:0]};
                     pleft_in = 3'd1;
                     phase_in = lvd_pkg::PH_PREFIX;
                  end else begin
                     len_in   = '0;
                     pleft_in = 3'(s1_byte_ff - lvd_pkg::MULTI_PREFIX_BASE);
                     phase_in = (s1_byte_ff == lvd_pkg::LONG_PREFIX_CODE) ?
                                lvd_pkg::PH_LONG_PREFIX : lvd_pkg::PH_PREFIX;
                  end
                  if (s1_eob_ff) begin
                     emit        = 1'b1;
                     emit_status = lvd_pkg::ST_TRUNC;
                  end
               end
            end
            lvd_pkg::PH_PREFIX, lvd_pkg::PH_LONG_PREFIX: begin
               len_in   = acc;
               pleft_in = pleft_dec;
               if (pleft_dec != 3'd0) begin
                  if (s1_eob_ff) begin
                     emit        = 1'b1;
                     emit_status = lvd_pkg::ST_TRUNC;
                  end
               end else if (phase_ff == lvd_pkg::PH_LONG_PREFIX && acc > max_len_ff) begin
                  emit        = 1'b1;
                  emit_len    = acc;
                  emit_status = lvd_pkg::ST_BADLEN;
               end else begin
                  lk_go  = 1'b1;
                  lk_len = acc;
               end
            end
            lvd_pkg::PH_PAYLOAD: begin
               if (held_ff == lvd_pkg::TY_INT) begin
                  if (pay_ff == len_ff) begin
                     int_in = {{56{s1_byte_ff[7]}}, s1_byte_ff};
                  end else begin
                     int_in = {int_ff[55:0], s1_byte_ff};
                  end
               end
               last_in = s1_byte_ff;
               pay_in  = pay_dec;
               if (pay_dec != 32'd0) begin
                  if (s1_eob_ff) begin
                     emit        = 1'b1;
                     emit_status = lvd_pkg::ST_TRUNC;
                  end
               end else begin
                  emit     = 1'b1;
                  emit_len = len_ff;
                  if (deferr_ff != lvd_pkg::ST_OK) begin
                     emit_status = deferr_ff;
                  end else if (held_ff == lvd_pkg::TY_INT) begin
                     emit_val = int_in;
                  end else if (held_ff == lvd_pkg::TY_NONE) begin
                     emit_status = lvd_pkg::ST_OK;
                  end else if (last_in != 8'd0) begin
                     emit_status = lvd_pkg::ST_NOTERM;
                  end else begin
                     emit_len = len_ff - 32'd1;
                  end
               end
            end
            lvd_pkg::PH_DISCARD: begin
               if (s1_eob_ff) begin
                  phase_in = lvd_pkg::PH_IDLE;
               end
            end
            default: begin
               phase_in = lvd_pkg::PH_IDLE;
            end
         endcase

         // length fully known
         if (lk_go) begin
            len_in = lk_len;
            if (lk_len == 32'd0) begin
               emit        = 1'b1;
               emit_status = (held_in == lvd_pkg::TY_INT) ?
                             lvd_pkg::ST_BADLEN : lvd_pkg::ST_OK;
            end else if (s1_eob_ff) begin
               emit        = 1'b1;
               emit_status = lvd_pkg::ST_TRUNC;
            end else begin
               pay_in    = lk_len;
               int_in    = '0;
               deferr_in = (held_in == lvd_pkg::TY_INT && lk_len > lvd_pkg::INT_MAX_BYTES) ?
                           lvd_pkg::ST_BADLEN : lvd_pkg::ST_OK;
               phase_in  = lvd_pkg::PH_PAYLOAD;
            end
         end

         // phase after a response
         if (emit) begin
            phase_in = (emit_status != lvd_pkg::ST_OK && !s1_eob_ff) ?
                       lvd_pkg::PH_DISCARD : lvd_pkg::PH_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= lvd_pkg::PH_IDLE;
         pleft_ff  <= '0;
         len_ff    <= '0;
         pay_ff    <= '0;
         int_ff    <= '0;
         held_ff   <= lvd_pkg::TY_NONE;
         last_ff   <= '0;
         deferr_ff <= lvd_pkg::ST_OK;
      end else begin
         phase_ff  <= phase_in;
         pleft_ff  <= pleft_in;
         len_ff    <= len_in;
         pay_ff    <= pay_in;
         int_ff    <= int_in;
         held_ff   <= held_in;
         last_ff   <= last_in;
         deferr_ff <= deferr_in;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = proc && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && emit) begin
         rsp_int_ff    <= emit_val;
         rsp_len_ff    <= emit_len;
         rsp_status_ff <= emit_status;
      end
   end

`ifndef SYNTHESIS
   // a byte marked end of buffer always leaves the parser waiting for a prefix
   assert property (@(posedge clock) disable iff (reset)
      (proc && s1_eob_ff) |=> (phase_ff == lvd_pkg::PH_IDLE))
      else $error("parser not idle after end of buffer");

   // a value in payload phase always has bytes left
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lvd_pkg::PH_PAYLOAD) |-> (pay_ff != 32'd0))
      else $error("payload phase with no bytes left");

   // truncation reports a zero length
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == lvd_pkg::ST_TRUNC) |-> (rsp_len_ff == 32'd0))
      else $error("truncation with non-zero length");

   // errors never carry an integer
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != lvd_pkg::ST_OK) |-> (rsp_int_ff == 64'sd0))
      else $error("error response with integer value");
`endif

endmodule
